@@ hw/rtl/blr_pkg.sv @@
// Shared types and constants for the line rasterizer.
// No dependencies; imported by the top, blr_front and blr_back (blr_fifo does not use it).
`timescale 1ns / 1ps

package blr_pkg;

    localparam int CoordW = 6;
    localparam int ColorW = 8;
    localparam int IndexW = 12;
    localparam int ErrW   = 10;

    localparam logic [ColorW-1:0] AlphaOpaque = 8'hFF;

    typedef logic [CoordW-1:0]        coord_t;
    typedef logic [ColorW-1:0]        color_t;
    typedef logic signed [ErrW-1:0]   err_t;

    // One classified segment, ready for the stepping engine.
    typedef struct packed {
        coord_t x;
        coord_t y;
        coord_t xe;
        coord_t ye;
        err_t   dx;
        err_t   dy;
        logic   x_dec;
        logic   y_dec;
        err_t   err;
        color_t red;
        color_t green;
        color_t blue;
    } seg_t;

    typedef struct packed {
        coord_t              x;
        coord_t              y;
        logic [IndexW-1:0]   index;
        color_t              red;
        color_t              green;
        color_t              blue;
        logic                last;
    } pixel_t;

endpackage

@@ hw/rtl/bresenham_line_rasterizer_top.sv @@
// Bresenham line rasterizer: one segment in, one pixel item per plotted pixel out. A
// segment of N pixels (N = max(|dx|,|dy|)+1, at most CANVAS_SIZE) goes through the single
// stepping engine, which emits one pixel per cycle unless the result queue is full;
// consecutive segments run with no gap, and a segment reaching an idle engine is first
// loaded into its register. A two-entry segment queue and a two-entry result queue
// decouple the input and result sides. Coordinates above CANVAS_SIZE-1 are clamped to
// it. Depends on blr_pkg, blr_front, blr_fifo and blr_back.
`timescale 1ns / 1ps

module bresenham_line_rasterizer_top #(
    parameter int CANVAS_SIZE = 64
) (
    input  logic             clk,
    input  logic             rst_n,
    input  logic             push,
    output logic             full,
    input  blr_pkg::coord_t  start_x,
    input  blr_pkg::coord_t  start_y,
    input  blr_pkg::coord_t  end_x,
    input  blr_pkg::coord_t  end_y,
    input  blr_pkg::color_t  red_in,
    input  blr_pkg::color_t  green_in,
    input  blr_pkg::color_t  blue_in,
    output logic             empty,
    input  logic             pop,
    output blr_pkg::coord_t  pixel_x,
    output blr_pkg::coord_t  pixel_y,
    output logic [blr_pkg::IndexW-1:0] pixel_index,
    output blr_pkg::color_t  red_out,
    output blr_pkg::color_t  green_out,
    output blr_pkg::color_t  blue_out,
    output blr_pkg::color_t  alpha_out,
    output logic             last_pixel
);
    import blr_pkg::*;

    seg_t   seg_in, seg_q;
    logic   seg_empty, seg_pop;
    logic   out_full, out_push;
    pixel_t pix_in, pix_q;

    blr_front #(.CANVAS_SIZE(CANVAS_SIZE)) u_front (
        .start_x  (start_x),
        .start_y  (start_y),
        .end_x    (end_x),
        .end_y    (end_y),
        .red_in   (red_in),
        .green_in (green_in),
        .blue_in  (blue_in),
        .seg      (seg_in)
    );

    blr_fifo #(.item_t(seg_t)) u_seg_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (push),
        .wr_data (seg_in),
        .full    (full),
        .pop     (seg_pop),
        .rd_data (seg_q),
        .empty   (seg_empty)
    );

    blr_back #(.CANVAS_SIZE(CANVAS_SIZE)) u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .seg_valid (!seg_empty),
        .seg       (seg_q),
        .seg_pop   (seg_pop),
        .out_full  (out_full),
        .out_push  (out_push),
        .pix       (pix_in)
    );

    blr_fifo #(.item_t(pixel_t)) u_pix_q (
        .clk     (clk),
        .rst_n   (rst_n),
        .push    (out_push),
        .wr_data (pix_in),
        .full    (out_full),
        .pop     (pop),
        .rd_data (pix_q),
        .empty   (empty)
    );

    assign pixel_x     = pix_q.x;
    assign pixel_y     = pix_q.y;
    assign pixel_index = pix_q.index;
    assign red_out     = pix_q.red;
    assign green_out   = pix_q.green;
    assign blue_out    = pix_q.blue;
    assign alpha_out   = AlphaOpaque;
    assign last_pixel  = pix_q.last;

endmodule

@@ hw/rtl/blr_fifo.sv @@
// Two-entry item queue, generic in its item type.
// Depends on nothing; used between front and back and at the result side.
`timescale 1ns / 1ps

module blr_fifo #(
    parameter type item_t = logic
) (
    input  logic  clk,
    input  logic  rst_n,
    input  logic  push,
    input  item_t wr_data,
    output logic  full,
    input  logic  pop,
    output item_t rd_data,
    output logic  empty
);

    item_t      mem_reg [2];
    logic       wr_ptr_reg, wr_ptr_next;
    logic       rd_ptr_reg, rd_ptr_next;
    logic [1:0] count_reg, count_next;
    logic       do_push, do_pop;

    assign full    = count_reg == 2'd2;
    assign empty   = count_reg == 2'd0;
    assign rd_data = mem_reg[rd_ptr_reg];
    assign do_push = push && !full;
    assign do_pop  = pop && !empty;

    always_comb
    begin
        wr_ptr_next = do_push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next = do_pop ? ~rd_ptr_reg : rd_ptr_reg;
        count_next  = count_reg + 2'(do_push) - 2'(do_pop);
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
            count_reg  <= 2'd0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
        begin
            mem_reg[wr_ptr_reg] <= wr_data;
        end
    end

    a_count_range: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg != 2'd3)
        else $error("queue count out of range");

    a_ptr_gap: assert property (@(posedge clk) disable iff (!rst_n)
        (count_reg == 2'd1) |-> (wr_ptr_reg != rd_ptr_reg))
        else $error("queue pointers disagree with count");

    a_count_track: assert property (@(posedge clk) disable iff (!rst_n)
        (do_push && !do_pop) |=> (count_reg == $past(count_reg) + 2'd1))
        else $error("queue count missed a push");

endmodule

@@ hw/rtl/blr_front.sv @@
// Front end: clamps the endpoints to the canvas and sets up the error term.
// Depends on blr_pkg.
`timescale 1ns / 1ps

module blr_front #(
    parameter int CANVAS_SIZE = 64
) (
    input  blr_pkg::coord_t start_x,
    input  blr_pkg::coord_t start_y,
    input  blr_pkg::coord_t end_x,
    input  blr_pkg::coord_t end_y,
    input  blr_pkg::color_t red_in,
    input  blr_pkg::color_t green_in,
    input  blr_pkg::color_t blue_in,
    output blr_pkg::seg_t   seg
);
    import blr_pkg::*;

    localparam coord_t MaxCoord = CoordW'(CANVAS_SIZE - 1);

    coord_t x0, y0, x1, y1;
    coord_t adx, ady;

    always_comb
    begin
        x0  = (start_x > MaxCoord) ? MaxCoord : start_x;
        y0  = (start_y > MaxCoord) ? MaxCoord : start_y;
        x1  = (end_x > MaxCoord) ? MaxCoord : end_x;
        y1  = (end_y > MaxCoord) ? MaxCoord : end_y;
        adx = (x1 > x0) ? x1 - x0 : x0 - x1;
        ady = (y1 > y0) ? y1 - y0 : y0 - y1;

        seg.x     = x0;
        seg.y     = y0;
        seg.xe    = x1;
        seg.ye    = y1;
        seg.dx    = err_t'({1'b0, adx});
        seg.dy    = -err_t'({1'b0, ady});
        seg.x_dec = !(x0 < x1);
        seg.y_dec = !(y0 < y1);
        seg.err   = err_t'({1'b0, adx}) - err_t'({1'b0, ady});
        seg.red   = red_in;
        seg.green = green_in;
        seg.blue  = blue_in;
    end

endmodule

@@ hw/rtl/blr_back.sv @@
// Back end: steps the error term one pixel per cycle while the result queue is not full, and emits pixel items.
// Depends on blr_pkg.
`timescale 1ns / 1ps

module blr_back #(
    parameter int CANVAS_SIZE = 64
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              seg_valid,
    input  blr_pkg::seg_t     seg,
    output logic              seg_pop,
    input  logic              out_full,
    output logic              out_push,
    output blr_pkg::pixel_t   pix
);
    import blr_pkg::*;

    localparam logic [IndexW-1:0] SizeIdx = IndexW'(CANVAS_SIZE);

    logic                active_reg, active_next;
    seg_t                cur_reg, cur_next;
    logic                done;
    logic signed [ErrW:0] e2;
    logic                step_x, step_y;

    always_comb
    begin
        done = (cur_reg.x == cur_reg.xe) && (cur_reg.y == cur_reg.ye);
        e2   = {cur_reg.err, 1'b0};
        step_x = e2 >= (ErrW+1)'(cur_reg.dy);
        step_y = e2 <= (ErrW+1)'(cur_reg.dx);

        pix.x     = cur_reg.x;
        pix.y     = cur_reg.y;
        pix.index = IndexW'(IndexW'(cur_reg.y) * SizeIdx) + IndexW'(cur_reg.x);
        pix.red   = cur_reg.red;
        pix.green = cur_reg.green;
        pix.blue  = cur_reg.blue;
        pix.last  = done;

        cur_next    = cur_reg;
        active_next = active_reg;
        seg_pop     = 1'b0;
        out_push    = 1'b0;

        if (active_reg)
        begin
            if (!out_full)
            begin
                out_push = 1'b1;
                if (done)
                begin
                    if (seg_valid)
                    begin
                        seg_pop  = 1'b1;
                        cur_next = seg;
                    end
                    else
                    begin
                        active_next = 1'b0;
                    end
                end
                else
                begin
                    if (step_x)
                    begin
                        cur_next.x = cur_reg.x_dec ? cur_reg.x - 1'b1 : cur_reg.x + 1'b1;
                    end
                    if (step_y)
                    begin
                        cur_next.y = cur_reg.y_dec ? cur_reg.y - 1'b1 : cur_reg.y + 1'b1;
                    end
                    cur_next.err = cur_reg.err + (step_x ? cur_reg.dy : '0)
                                   + (step_y ? cur_reg.dx : '0);
                end
            end
        end
        else if (seg_valid)
        begin
            seg_pop     = 1'b1;
            cur_next    = seg;
            active_next = 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg <= 1'b0;
        end
        else
        begin
            active_reg <= active_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cur_reg <= cur_next;
    end

    a_push_active: assert property (@(posedge clk) disable iff (!rst_n)
        out_push |-> (active_reg && !out_full))
        else $error("pixel pushed while idle or into a full queue");

    a_run_continues: assert property (@(posedge clk) disable iff (!rst_n)
        (out_push && !done) |=> active_reg)
        else $error("run stopped before its end point");

    a_run_moves: assert property (@(posedge clk) disable iff (!rst_n)
        (out_push && !done) |=>
            (cur_reg.x != $past(cur_reg.x)) || (cur_reg.y != $past(cur_reg.y)))
        else $error("step did not move the pixel");

    a_pop_when_free: assert property (@(posedge clk) disable iff (!rst_n)
        seg_pop |-> (seg_valid && (!active_reg || (out_push && done))))
        else $error("segment taken while a run is in progress");

endmodule

@@ verif/tb_top.sv @@
// Self-checking testbench for bresenham_line_rasterizer_top: segments go in, pixel items
// come out and are compared against an in-bench Bresenham walk. Depends on blr_pkg and
// the rasterizer RTL.
`timescale 1ns / 1ps

module tb_top;
    import blr_pkg::*;

    localparam int CANVAS = 64;

    class line_scoreboard;
        pixel_t pending[$];
        int     errors = 0;

        function int fit_canvas(input coord_t v);
            return (int'(v) > CANVAS - 1) ? CANVAS - 1 : int'(v);
        endfunction

        function void note_segment(input coord_t sx, input coord_t sy, input coord_t ex,
                                   input coord_t ey, input color_t r, input color_t g,
                                   input color_t b);
            int     x, y, xe, ye, dx, dy, step_x, step_y, err, e2;
            bit     at_end;
            pixel_t px;
            x      = fit_canvas(sx);
            y      = fit_canvas(sy);
            xe     = fit_canvas(ex);
            ye     = fit_canvas(ey);
            dx     = (xe > x) ? xe - x : x - xe;
            dy     = -((ye > y) ? ye - y : y - ye);
            step_x = (x < xe) ? 1 : -1;
            step_y = (y < ye) ? 1 : -1;
            err    = dx + dy;
            for (int n = 0; n < CANVAS; n++)
            begin
                at_end   = (x == xe) && (y == ye);
                px.x     = coord_t'(x);
                px.y     = coord_t'(y);
                px.index = IndexW'(y * CANVAS + x);
                px.red   = r;
                px.green = g;
                px.blue  = b;
                px.last  = at_end;
                pending  = {pending, px};
                if (at_end)
                    break;
                e2 = 2 * err;
                if (e2 >= dy)
                begin
                    err += dy;
                    x   += step_x;
                end
                if (e2 <= dx)
                begin
                    err += dx;
                    y   += step_y;
                end
            end
        endfunction

        function void compare_field(input string name, input int want, input int got);
            if (want != got)
            begin
                $error("%s expected %0d got %0d", name, want, got);
                errors++;
            end
        endfunction

        function void check_pixel(input pixel_t got, input color_t alpha);
            pixel_t want;
            if (pending.size() == 0)
            begin
                $error("pixel_x/pixel_y %0d/%0d arrived with no item expected", got.x, got.y);
                errors++;
                return;
            end
            want = pending.pop_front();
            compare_field("pixel_x", want.x, got.x);
            compare_field("pixel_y", want.y, got.y);
            compare_field("pixel_index", want.index, got.index);
            compare_field("red_out", want.red, got.red);
            compare_field("green_out", want.green, got.green);
            compare_field("blue_out", want.blue, got.blue);
            compare_field("alpha_out", AlphaOpaque, alpha);
            compare_field("last_pixel", want.last, got.last);
        endfunction
    endclass

    logic   clk      = 1'b0;
    logic   rst_n    = 1'b0;
    logic   push     = 1'b0;
    logic   pop      = 1'b0;
    coord_t start_x  = '0;
    coord_t start_y  = '0;
    coord_t end_x    = '0;
    coord_t end_y    = '0;
    color_t red_in   = '0;
    color_t green_in = '0;
    color_t blue_in  = '0;

    logic              full;
    logic              empty;
    coord_t            pixel_x;
    coord_t            pixel_y;
    logic [IndexW-1:0] pixel_index;
    color_t            red_out;
    color_t            green_out;
    color_t            blue_out;
    color_t            alpha_out;
    logic              last_pixel;

    bit send_idle = 1'b1;
    bit pop_idle  = 1'b1;

    line_scoreboard pixel_board = new();

    bresenham_line_rasterizer_top #(
        .CANVAS_SIZE(CANVAS)
    ) u_dut (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .full       (full),
        .start_x    (start_x),
        .start_y    (start_y),
        .end_x      (end_x),
        .end_y      (end_y),
        .red_in     (red_in),
        .green_in   (green_in),
        .blue_in    (blue_in),
        .empty      (empty),
        .pop        (pop),
        .pixel_x    (pixel_x),
        .pixel_y    (pixel_y),
        .pixel_index(pixel_index),
        .red_out    (red_out),
        .green_out  (green_out),
        .blue_out   (blue_out),
        .alpha_out  (alpha_out),
        .last_pixel (last_pixel)
    );

    always #5 clk = ~clk;

    always @(posedge clk)
    begin
        if (rst_n && pop && !empty)
            pixel_board.check_pixel('{x: pixel_x, y: pixel_y, index: pixel_index,
                                       red: red_out, green: green_out, blue: blue_out,
                                       last: last_pixel}, alpha_out);
    end

    task automatic send_segment(input coord_t sx, input coord_t sy, input coord_t ex,
                                input coord_t ey, input color_t r, input color_t g,
                                input color_t b);
        int gap;
        gap = send_idle ? $urandom_range(0, 4) : 0;
        if (gap > 0)
        begin
            push <= 1'b0;
            repeat (gap) @(posedge clk);
        end
        push     <= 1'b1;
        start_x  <= sx;
        start_y  <= sy;
        end_x    <= ex;
        end_y    <= ey;
        red_in   <= r;
        green_in <= g;
        blue_in  <= b;
        do @(posedge clk); while (full);
        pixel_board.note_segment(sx, sy, ex, ey, r, g, b);
    endtask

    task automatic drain_pixels();
        push <= 1'b0;
        while (pixel_board.pending.size() != 0)
            @(posedge clk);
    endtask

    // result side: random stalls per item
    initial
    begin
        int stall;
        while (!rst_n)
            @(posedge clk);
        forever
        begin
            stall = pop_idle ? $urandom_range(0, 4) : 0;
            if (stall > 0)
            begin
                pop <= 1'b0;
                repeat (stall) @(posedge clk);
            end
            pop <= 1'b1;
            do @(posedge clk); while (empty);
        end
    end

    initial
    begin
        #5_000_000;
        $display("DONE: errors detected");
        $finish;
    end

    initial
    begin
        coord_t ax, ay, bx, by;
        int     reach, tx, ty;
        repeat (6) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // degenerate points, full-length lines, every octant, color extremes
        send_segment(6'd0, 6'd0, 6'd0, 6'd0, 8'h00, 8'h00, 8'h00);
        send_segment(6'd63, 6'd63, 6'd63, 6'd63, 8'hFF, 8'hFF, 8'hFF);
        send_segment(6'd0, 6'd0, 6'd63, 6'd0, 8'h55, 8'hAA, 8'h55);
        send_segment(6'd63, 6'd63, 6'd0, 6'd63, 8'hAA, 8'h55, 8'hAA);
        send_segment(6'd0, 6'd0, 6'd0, 6'd63, 8'hFF, 8'h00, 8'h80);
        send_segment(6'd63, 6'd63, 6'd63, 6'd0, 8'h00, 8'hFF, 8'h01);
        send_segment(6'd0, 6'd0, 6'd63, 6'd63, 8'h80, 8'h01, 8'hFE);
        send_segment(6'd63, 6'd0, 6'd0, 6'd63, 8'h01, 8'hFE, 8'h7F);
        send_segment(6'd63, 6'd63, 6'd0, 6'd0, 8'hFE, 8'h7F, 8'h80);
        send_segment(6'd0, 6'd63, 6'd63, 6'd0, 8'h7F, 8'h80, 8'hFF);
        send_segment(6'd10, 6'd10, 6'd30, 6'd17, 8'h12, 8'h34, 8'h56);
        send_segment(6'd10, 6'd10, 6'd17, 6'd30, 8'h9A, 8'hBC, 8'hDE);
        send_segment(6'd10, 6'd10, 6'd3, 6'd30, 8'h21, 8'h43, 8'h65);
        send_segment(6'd10, 6'd10, 6'd0, 6'd17, 8'h87, 8'hA9, 8'hCB);
        send_segment(6'd30, 6'd30, 6'd10, 6'd23, 8'hED, 8'h0F, 8'h1E);
        send_segment(6'd30, 6'd30, 6'd23, 6'd10, 8'h2D, 8'h3C, 8'h4B);
        send_segment(6'd30, 6'd30, 6'd37, 6'd10, 8'h5A, 8'h69, 8'h78);
        send_segment(6'd30, 6'd30, 6'd50, 6'd23, 8'h87, 8'h96, 8'hA5);
        send_segment(6'd21, 6'd42, 6'd22, 6'd43, 8'hC3, 8'hD2, 8'hE1);
        send_segment(6'd42, 6'd21, 6'd42, 6'd21, 8'hF0, 8'h0F, 8'hF0);
        drain_pixels();

        for (int n = 0; n < 230; n++)
        begin
            // vary idling per quarter; the last quarter runs back to back
            if (n % 58 == 0)
            begin
                send_idle = (n / 58) < 2;
                pop_idle  = (n / 58) != 1 && (n / 58) != 3;
            end
            if (n == 115)
                drain_pixels();
            ax = coord_t'($urandom_range(0, 63));
            ay = coord_t'($urandom_range(0, 63));
            if ($urandom_range(0, 3) == 0)
            begin
                bx = coord_t'($urandom_range(0, 63));
                by = coord_t'($urandom_range(0, 63));
            end
            else
            begin
                reach = $urandom_range(0, 8);
                tx = int'(ax) + int'($urandom_range(0, 2 * reach)) - reach;
                ty = int'(ay) + int'($urandom_range(0, 2 * reach)) - reach;
                bx = coord_t'((tx < 0) ? 0 : (tx > 63) ? 63 : tx);
                by = coord_t'((ty < 0) ? 0 : (ty > 63) ? 63 : ty);
            end
            send_segment(ax, ay, bx, by, color_t'($urandom_range(0, 255)),
                         color_t'($urandom_range(0, 255)), color_t'($urandom_range(0, 255)));
        end

        drain_pixels();
        repeat (80) @(posedge clk);
        if (pixel_board.errors == 0 && pixel_board.pending.size() == 0)
            $display("DONE: 0 errors");
        else
            $display("DONE: errors detected");
        $finish;
    end

endmodule

@@ filelist.f @@
hw/rtl/blr_pkg.sv
hw/rtl/blr_fifo.sv
hw/rtl/blr_front.sv
hw/rtl/blr_back.sv
hw/rtl/bresenham_line_rasterizer_top.sv
verif/tb_top.sv
